@@ hw/rtl/bxrng_pkg.sv @@
// Package: constants and types shared by the bounded xoshiro256** generator.
package bxrng_pkg;
  localparam int unsigned WordW = 64;
  localparam logic [WordW-1:0] GoldenGamma = 64'h9E3779B97F4A7C15;
  localparam logic [WordW-1:0] MixMulA = 64'hBF58476D1CE4E5B9;
  localparam logic [WordW-1:0] MixMulB = 64'h94D049BB133111EB;
  localparam logic [WordW-1:0] MulFive = 64'd5;
  localparam logic [WordW-1:0] MulNine = 64'd9;
  localparam logic [0:0] RegSeed = 1'b0;

  typedef logic [WordW-1:0] word_t;

  // multiplier request and response
  typedef struct packed {
    logic start;
    word_t a;
    word_t b;
  } mul_req_t;

  typedef struct packed {
    logic done;
    word_t p;
  } mul_rsp_t;

  typedef struct packed {
    logic start;
    word_t n;
    word_t d;
  } div_req_t;

  typedef struct packed {
    logic done;
    word_t rem;
  } div_rsp_t;
endpackage

@@ hw/rtl/bxrng_mul.sv @@
// Bit-serial 64x64 multiplier, low 64 bits of the product, one bit per cycle.
module bxrng_mul (
  input  logic clk,
  input  logic rst_n,
  input  bxrng_pkg::mul_req_t req,
  output bxrng_pkg::mul_rsp_t rsp
);
  import bxrng_pkg::*;

  word_t a_r, a_nxt, b_r, b_nxt, p_r, p_nxt;
  logic [6:0] cnt_r, cnt_nxt;
  logic busy_r, busy_nxt, done_r, done_nxt;

  always_comb begin
    a_nxt = a_r;
    b_nxt = b_r;
    p_nxt = p_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      a_nxt = req.a;
      b_nxt = req.b;
      p_nxt = '0;
      cnt_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (b_r[0]) p_nxt = p_r + a_r;
      a_nxt = {a_r[WordW-2:0], 1'b0};
      b_nxt = {1'b0, b_r[WordW-1:1]};
      cnt_nxt = cnt_r + 7'd1;
      if (cnt_r == 7'(WordW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    a_r <= a_nxt;
    b_r <= b_nxt;
    p_r <= p_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign rsp.done = done_r;
  assign rsp.p = p_r;
endmodule

@@ hw/rtl/bxrng_div.sv @@
// Bit-serial restoring divider, 64-bit remainder, one quotient bit per cycle.
module bxrng_div (
  input  logic clk,
  input  logic rst_n,
  input  bxrng_pkg::div_req_t req,
  output bxrng_pkg::div_rsp_t rsp
);
  import bxrng_pkg::*;

  word_t n_r, n_nxt, d_r, d_nxt;
  word_t rem_r, rem_nxt;
  logic [WordW:0] trial;
  logic [WordW:0] diff;
  logic [6:0] cnt_r, cnt_nxt;
  logic busy_r, busy_nxt, done_r, done_nxt;

  always_comb begin
    n_nxt = n_r;
    d_nxt = d_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial = {rem_r, n_r[WordW-1]};
    diff = trial - {1'b0, d_r};
    if (req.start) begin
      n_nxt = req.n;
      d_nxt = req.d;
      rem_nxt = '0;
      cnt_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, d_r}) rem_nxt = diff[WordW-1:0];
      else rem_nxt = trial[WordW-1:0];
      n_nxt = {n_r[WordW-2:0], 1'b0};
      cnt_nxt = cnt_r + 7'd1;
      if (cnt_r == 7'(WordW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    n_r <= n_nxt;
    d_r <= d_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign rsp.done = done_r;
  assign rsp.rem = rem_r;
endmodule

@@ hw/rtl/bounded_xoshiro256ss_rng.sv @@
// Top level: bounded xoshiro256** generator with SplitMix64 seeding.
// One request carries an inclusive range and returns one 64-bit value in it.
// The first request with a valid range seeds the generator: four SplitMix64
// steps, each two serial multiplies. A full-range request then takes two
// serial multiplies; any other range adds one serial remainder for the
// threshold, redraws with two more multiplies while a draw falls below the
// threshold, and takes one remainder of the accepted draw. An inverted range
// skips seeding and drawing and answers with the error flag set.
// The next request is taken once the result has left the output register.
module bounded_xoshiro256ss_rng (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,   // range_low [63:0], range_high [127:64]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [63:0]  out_tdata,  // random_value [63:0]
  output logic         out_tuser,  // range_error
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [3:0]   cfg_paddr,
  input  logic [63:0]  cfg_pwdata,
  output logic [63:0]  cfg_prdata,
  output logic         cfg_pready
);
  import bxrng_pkg::*;

  typedef enum logic [13:0] {
    S_IDLE  = 14'b00000000000001,
    S_SMADD = 14'b00000000000010,
    S_SMM1  = 14'b00000000000100,
    S_SMM2  = 14'b00000000001000,
    S_SMFIN = 14'b00000000010000,
    S_RANGE = 14'b00000000100000,
    S_THR   = 14'b00000001000000,
    S_OM5   = 14'b00000010000000,
    S_OM9   = 14'b00000100000000,
    S_CHK   = 14'b00001000000000,
    S_VMOD  = 14'b00010000000000,
    S_OUT   = 14'b00100000000000,
    S_WAIT  = 14'b01000000000000,
    S_FULL  = 14'b10000000000000
  } state_t;

  state_t st_r, st_nxt;
  word_t seed_r, s_r, s_nxt, lo_r, lo_nxt, size_r, size_nxt, thr_r, thr_nxt;
  word_t v_r, v_nxt, res_r, res_nxt;
  word_t w0_r, w0_nxt, w1_r, w1_nxt, w2_r, w2_nxt, w3_r, w3_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic seeded_r, seeded_nxt, full_r, full_nxt, err_r, err_nxt, ov_r, ov_nxt;
  mul_req_t mreq;
  mul_rsp_t mrsp;
  div_req_t dreq;
  div_rsp_t drsp;
  word_t lo_in, hi_in, z, o7, t2, t3, t1;

  bxrng_mul u_mul (.clk, .rst_n, .req(mreq), .rsp(mrsp));
  bxrng_div u_div (.clk, .rst_n, .req(dreq), .rsp(drsp));

  assign lo_in = in_tdata[63:0];
  assign hi_in = in_tdata[127:64];
  assign in_tready = (st_r == S_IDLE) && !ov_r;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[3] == RegSeed) ? seed_r : '0;
  assign out_tvalid = ov_r;
  assign out_tdata = res_r;
  assign out_tuser = err_r;

  always_comb begin
    st_nxt = st_r;
    s_nxt = s_r; lo_nxt = lo_r; size_nxt = size_r; thr_nxt = thr_r;
    v_nxt = v_r; res_nxt = res_r; idx_nxt = idx_r;
    w0_nxt = w0_r; w1_nxt = w1_r; w2_nxt = w2_r; w3_nxt = w3_r;
    seeded_nxt = seeded_r; full_nxt = full_r; err_nxt = err_r; ov_nxt = ov_r;
    mreq = '0;
    dreq = '0;
    z = mrsp.p;
    o7 = {mrsp.p[WordW-8:0], mrsp.p[WordW-1:WordW-7]};
    t2 = w2_r ^ w0_r;
    t3 = w3_r ^ w1_r;
    t1 = w1_r ^ t2;
    if (ov_r && out_tready) ov_nxt = 1'b0;
    unique case (st_r)
      S_IDLE: begin
        if (in_tvalid && !ov_r) begin
          lo_nxt = lo_in;
          size_nxt = hi_in - lo_in + 64'd1;
          full_nxt = (lo_in == '0) && (hi_in == '1);
          if (hi_in < lo_in) begin
            res_nxt = '0;
            err_nxt = 1'b1;
            st_nxt = S_OUT;
          end else if (!seeded_r) begin
            s_nxt = seed_r;
            idx_nxt = '0;
            st_nxt = S_SMADD;
          end else st_nxt = S_RANGE;
        end
      end
      S_SMADD: begin
        s_nxt = s_r + GoldenGamma;
        mreq.start = 1'b1;
        mreq.a = (s_r + GoldenGamma) ^ ((s_r + GoldenGamma) >> 30);
        mreq.b = MixMulA;
        st_nxt = S_SMM1;
      end
      S_SMM1: if (mrsp.done) begin
        mreq.start = 1'b1;
        mreq.a = z ^ (z >> 27);
        mreq.b = MixMulB;
        st_nxt = S_SMM2;
      end
      S_SMM2: if (mrsp.done) begin
        unique case (idx_r)
          2'd0: w0_nxt = z ^ (z >> 31);
          2'd1: w1_nxt = z ^ (z >> 31);
          2'd2: w2_nxt = z ^ (z >> 31);
          default: w3_nxt = z ^ (z >> 31);
        endcase
        idx_nxt = idx_r + 2'd1;
        st_nxt = (idx_r == 2'd3) ? S_SMFIN : S_SMADD;
      end
      S_SMFIN: begin
        if ((w0_r | w1_r | w2_r | w3_r) == '0) w0_nxt = GoldenGamma;
        seeded_nxt = 1'b1;
        st_nxt = S_RANGE;
      end
      S_RANGE: begin
        if (full_r) begin
          thr_nxt = '0;
          mreq.start = 1'b1;
          mreq.a = w1_r;
          mreq.b = MulFive;
          st_nxt = S_OM5;
        end else begin
          dreq.start = 1'b1;
          dreq.n = '0 - size_r;
          dreq.d = size_r;
          st_nxt = S_THR;
        end
      end
      S_THR: if (drsp.done) begin
        thr_nxt = drsp.rem;
        mreq.start = 1'b1;
        mreq.a = w1_r;
        mreq.b = MulFive;
        st_nxt = S_OM5;
      end
      S_OM5: if (mrsp.done) begin
        mreq.start = 1'b1;
        mreq.a = o7;
        mreq.b = MulNine;
        w2_nxt = t2 ^ (w1_r << 17);
        w3_nxt = {t3[WordW-46:0], t3[WordW-1:WordW-45]};
        w1_nxt = t1;
        w0_nxt = w0_r ^ t3;
        st_nxt = S_OM9;
      end
      S_OM9: if (mrsp.done) begin
        v_nxt = mrsp.p;
        st_nxt = full_r ? S_FULL : S_CHK;
      end
      S_FULL: begin
        res_nxt = v_r;
        err_nxt = 1'b0;
        st_nxt = S_OUT;
      end
      S_CHK: begin
        if (v_r < thr_r) begin
          mreq.start = 1'b1;
          mreq.a = w1_r;
          mreq.b = MulFive;
          st_nxt = S_OM5;
        end else begin
          dreq.start = 1'b1;
          dreq.n = v_r;
          dreq.d = size_r;
          st_nxt = S_VMOD;
        end
      end
      S_VMOD: if (drsp.done) begin
        res_nxt = lo_r + drsp.rem;
        err_nxt = 1'b0;
        st_nxt = S_OUT;
      end
      S_OUT: begin
        ov_nxt = 1'b1;
        st_nxt = S_WAIT;
      end
      S_WAIT: st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    s_r <= s_nxt; lo_r <= lo_nxt; size_r <= size_nxt; thr_r <= thr_nxt;
    v_r <= v_nxt; res_r <= res_nxt; idx_r <= idx_nxt; full_r <= full_nxt;
    err_r <= err_nxt;
    if (!rst_n) begin
      st_r <= S_IDLE;
      seed_r <= '0;
      seeded_r <= 1'b0;
      ov_r <= 1'b0;
      w0_r <= '0; w1_r <= '0; w2_r <= '0; w3_r <= '0;
    end else begin
      st_r <= st_nxt;
      seeded_r <= seeded_nxt;
      ov_r <= ov_nxt;
      w0_r <= w0_nxt; w1_r <= w1_nxt; w2_r <= w2_nxt; w3_r <= w3_nxt;
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr[3] == RegSeed)
        seed_r <= cfg_pwdata;
    end
  end
endmodule

@@ hw/rtl/bxrng_checker.sv @@
// Port-level checker for the bounded generator, bound to the top level.
module bxrng_props (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic [127:0] in_tdata,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [63:0]  out_tdata,
  input logic         out_tuser
);
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == 64'd0)
    else $error("error result carries nonzero value");
  a_inv_err: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tdata[127:64] < in_tdata[63:0])
    |-> ##2 out_tvalid && out_tuser)
    else $error("inverted range not flagged");
  a_one_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("request taken while result pending");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");
endmodule

bind bounded_xoshiro256ss_rng bxrng_props u_bxrng_props (
  .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata,
  .out_tvalid, .out_tready, .out_tdata, .out_tuser
);
